### rtl/pazc_pkg.sv
`default_nettype none

package pazc_pkg;

   // Field widths
   localparam int unsigned TickWidth   = 16;
   localparam int unsigned DelayWidth  = 8;
   localparam int unsigned WindowWidth = 15;
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned IndexWidth  = 3;
   localparam int unsigned DataWidth   = 16;

   // Register indexes
   localparam logic [IndexWidth-1:0] REG_INIT_TICKS       = 3'd0;
   localparam logic [IndexWidth-1:0] REG_TICKS_PER_SECOND = 3'd1;
   localparam logic [IndexWidth-1:0] REG_DELAY_SECONDS    = 3'd2;
   localparam logic [IndexWidth-1:0] REG_INTERVAL_SECONDS = 3'd3;
   localparam logic [IndexWidth-1:0] REG_ZERO_WINDOW      = 3'd4;
   localparam logic [IndexWidth-1:0] REG_STORED_ZERO      = 3'd5;

   // Register reset values
   localparam logic [TickWidth-1:0]   INIT_TICKS_RST       = 16'd3000;
   localparam logic [TickWidth-1:0]   TICKS_PER_SECOND_RST = 16'd5000;
   localparam logic [DelayWidth-1:0]  DELAY_SECONDS_RST    = 8'd60;
   localparam logic [TickWidth-1:0]   INTERVAL_SECONDS_RST = 16'd3600;
   localparam logic [WindowWidth-1:0] ZERO_WINDOW_RST      = 15'd15;
   localparam logic [SampleWidth-1:0] STORED_ZERO_RST      = 16'd0;

   // Lockout timer phase
   typedef enum logic [2:0] {
      DLY_IDLE = 3'b001,
      DLY_RUN  = 3'b010,
      DLY_DONE = 3'b100
   } dly_phase_type;

   // Configuration as seen by the core
   typedef struct packed {
      logic [TickWidth-1:0]          init_ticks;
      logic [TickWidth-1:0]          ticks_per_second;
      logic [DelayWidth-1:0]         delay_seconds;
      logic [TickWidth-1:0]          interval_seconds;
      logic [WindowWidth-1:0]        zero_window;
      logic                          zero_load;
      logic signed [SampleWidth-1:0] zero_load_value;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic                          initialized;
      logic                          run_mode;
      logic signed [SampleWidth-1:0] zero_point;
      logic                          zero_written;
   } res_type;

endpackage

`default_nettype wire

### rtl/pazc_csr.sv
`default_nettype none

module pazc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [pazc_pkg::IndexWidth-1:0]    csr_index,
   input  wire logic [pazc_pkg::DataWidth-1:0]     csr_wdata,
   output pazc_pkg::cfg_type                       cfg
);

   logic [pazc_pkg::TickWidth-1:0]   init_ticks_ff;
   logic [pazc_pkg::TickWidth-1:0]   ticks_per_second_ff;
   logic [pazc_pkg::DelayWidth-1:0]  delay_seconds_ff;
   logic [pazc_pkg::TickWidth-1:0]   interval_seconds_ff;
   logic [pazc_pkg::WindowWidth-1:0] zero_window_ff;

   // Decode register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ticks_ff       <= pazc_pkg::INIT_TICKS_RST;
         ticks_per_second_ff <= pazc_pkg::TICKS_PER_SECOND_RST;
         delay_seconds_ff    <= pazc_pkg::DELAY_SECONDS_RST;
         interval_seconds_ff <= pazc_pkg::INTERVAL_SECONDS_RST;
         zero_window_ff      <= pazc_pkg::ZERO_WINDOW_RST;
      end else if (csr_we) begin
         case (csr_index)
            pazc_pkg::REG_INIT_TICKS:       init_ticks_ff       <= csr_wdata;
            pazc_pkg::REG_TICKS_PER_SECOND: ticks_per_second_ff <= csr_wdata;
            pazc_pkg::REG_DELAY_SECONDS:
               delay_seconds_ff <= csr_wdata[pazc_pkg::DelayWidth-1:0];
            pazc_pkg::REG_INTERVAL_SECONDS: interval_seconds_ff <= csr_wdata;
            pazc_pkg::REG_ZERO_WINDOW:
               zero_window_ff <= csr_wdata[pazc_pkg::WindowWidth-1:0];
            default: ;
         endcase
      end
   end

   // Stored zero goes straight into the core's zero register
   assign cfg.init_ticks       = init_ticks_ff;
   assign cfg.ticks_per_second = ticks_per_second_ff;
   assign cfg.delay_seconds    = delay_seconds_ff;
   assign cfg.interval_seconds = interval_seconds_ff;
   assign cfg.zero_window      = zero_window_ff;
   assign cfg.zero_load        = csr_we && (csr_index == pazc_pkg::REG_STORED_ZERO);
   assign cfg.zero_load_value  = csr_wdata;

endmodule

`default_nettype wire

### rtl/pazc_core.sv
`default_nettype none

module pazc_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pazc_pkg::cfg_type                     cfg,
   input  wire logic                                  take,
   input  wire logic                                  start_pressed,
   input  wire logic signed [pazc_pkg::SampleWidth-1:0] pressure,
   output pazc_pkg::res_type                          res
);

   logic                                  init_done_ff, init_done_in;
   logic [pazc_pkg::TickWidth-1:0]        init_count_ff, init_count_in;
   pazc_pkg::dly_phase_type               dly_phase_ff, dly_phase_in;
   logic [pazc_pkg::TickWidth-1:0]        dly_ticks_ff, dly_ticks_in;
   logic [pazc_pkg::DelayWidth-1:0]       dly_secs_ff, dly_secs_in;
   logic                                  ivl_run_ff, ivl_run_in;
   logic [pazc_pkg::TickWidth-1:0]        ivl_ticks_ff, ivl_ticks_in;
   logic [pazc_pkg::TickWidth-1:0]        ivl_secs_ff, ivl_secs_in;
   logic                                  ivl_due_ff, ivl_due_in;
   logic                                  armed_off_ff, armed_off_in;
   logic signed [pazc_pkg::SampleWidth-1:0] zero_ff, zero_in;
   logic                                  mode_run_ff, mode_run_in;
   logic                                  written;
   logic [pazc_pkg::SampleWidth-1:0]      mag;

   // Magnitude of the sample; the most negative value stays 0x8000
   assign mag = pressure[pazc_pkg::SampleWidth-1] ? (~pressure + 16'd1) : pressure;

   // Timers first, then the operation logic, in tick order
   always_comb begin
      init_done_in = init_done_ff;
      init_count_in = init_count_ff;
      dly_phase_in = dly_phase_ff;
      dly_ticks_in = dly_ticks_ff;
      dly_secs_in = dly_secs_ff;
      ivl_run_in = ivl_run_ff;
      ivl_ticks_in = ivl_ticks_ff;
      ivl_secs_in = ivl_secs_ff;
      ivl_due_in = ivl_due_ff;
      armed_off_in = armed_off_ff;
      zero_in = zero_ff;
      mode_run_in = mode_run_ff;
      written = 1'b0;

      // startup timer
      if (!init_done_ff) begin
         init_count_in = init_count_ff + 16'd1;
         if (init_count_in > cfg.init_ticks) begin
            init_count_in = '0;
            init_done_in = 1'b1;
         end
      end

      // lockout timer
      if (dly_phase_ff == pazc_pkg::DLY_RUN) begin
         dly_ticks_in = dly_ticks_ff + 16'd1;
         if (dly_ticks_in > cfg.ticks_per_second) begin
            dly_ticks_in = '0;
            dly_secs_in = dly_secs_ff + 8'd1;
         end
         if (dly_secs_in > cfg.delay_seconds) begin
            dly_secs_in = '0;
            dly_phase_in = pazc_pkg::DLY_DONE;
         end
      end

      // interval timer
      if (ivl_run_ff) begin
         ivl_ticks_in = ivl_ticks_ff + 16'd1;
         if (ivl_ticks_in > cfg.ticks_per_second) begin
            ivl_ticks_in = '0;
            ivl_secs_in = ivl_secs_ff + 16'd1;
         end
         if (ivl_secs_in > cfg.interval_seconds) begin
            ivl_due_in = 1'b1;
            ivl_secs_in = '0;
            ivl_ticks_in = '0;
         end
      end

      // operation logic
      if (init_done_in) begin
         if (start_pressed) begin
            if (!armed_off_ff) begin
               zero_in = pressure;
               written = 1'b1;
               armed_off_in = 1'b1;
               dly_ticks_in = '0;
               dly_secs_in = '0;
               dly_phase_in = pazc_pkg::DLY_RUN;
            end
            ivl_run_in = 1'b1;
            if (ivl_due_in) begin
               ivl_due_in = 1'b0;
               if (mag < {1'b0, cfg.zero_window}) begin
                  zero_in = pressure;
                  written = 1'b1;
               end
            end
            mode_run_in = 1'b1;
         end else begin
            if (dly_phase_in == pazc_pkg::DLY_DONE) begin
               armed_off_in = 1'b0;
            end
            ivl_ticks_in = '0;
            ivl_secs_in = '0;
            ivl_run_in = 1'b0;
            mode_run_in = 1'b0;
         end
      end
   end

   // Stored-zero write reloads the zero; else an accepted item advances state
   always_ff @(posedge clock) begin
      if (reset) begin
         init_done_ff <= 1'b0;
         init_count_ff <= '0;
         dly_phase_ff <= pazc_pkg::DLY_IDLE;
         dly_ticks_ff <= '0;
         dly_secs_ff <= '0;
         ivl_run_ff <= 1'b0;
         ivl_ticks_ff <= '0;
         ivl_secs_ff <= '0;
         ivl_due_ff <= 1'b0;
         armed_off_ff <= 1'b0;
         zero_ff <= pazc_pkg::STORED_ZERO_RST;
         mode_run_ff <= 1'b0;
      end else if (cfg.zero_load) begin
         zero_ff <= cfg.zero_load_value;
      end else if (take) begin
         init_done_ff <= init_done_in;
         init_count_ff <= init_count_in;
         dly_phase_ff <= dly_phase_in;
         dly_ticks_ff <= dly_ticks_in;
         dly_secs_ff <= dly_secs_in;
         ivl_run_ff <= ivl_run_in;
         ivl_ticks_ff <= ivl_ticks_in;
         ivl_secs_ff <= ivl_secs_in;
         ivl_due_ff <= ivl_due_in;
         armed_off_ff <= armed_off_in;
         zero_ff <= zero_in;
         mode_run_ff <= mode_run_in;
      end
   end

   assign res.initialized  = init_done_in;
   assign res.run_mode     = mode_run_in;
   assign res.zero_point   = zero_in;
   assign res.zero_written = written;

endmodule

`default_nettype wire

### rtl/pazc_out.sv
`default_nettype none

module pazc_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire pazc_pkg::res_type res,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output pazc_pkg::res_type      rsp_data,
   output logic                   room
);

   logic              valid_ff, valid_in;
   pazc_pkg::res_type data_ff;

   // The register has room when empty or being drained this cycle
   assign room     = !valid_ff || !rsp_stall;
   assign valid_in = take || (valid_ff && rsp_stall);

   // Hold the valid flag until the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new item only when one is accepted
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### rtl/pressure_auto_zero_controller.sv
`default_nettype none

// Pressure auto-zero controller.
// Each request item is one timer tick: start switch state and a signed pressure
// sample. Each tick yields exactly one response item with the initialized flag,
// run/stop mode, the current zero point and a strobe that is high when the zero
// point was captured on that tick (write strobe for the nonvolatile store).
// The response is valid in the cycle after the request is accepted. Throughput
// is one item per cycle unless the receiver stalls; all timer and capture logic
// settles within the accept cycle and is registered into the response register.
// When the receiver stalls, the response register holds its item and the
// request side stalls in the same cycle; a response slot freed by a taken item
// lets a new request in on that same edge.
// Synchronous reset restores register defaults, clears all timers, returns to
// stop mode with capture armed and sets the zero point to zero.
// The user must write configuration (csr_we/csr_index/csr_wdata) only while
// idle (not enforced by the block). A stored zero write reloads the zero point.
module pressure_auto_zero_controller (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_we,
   input  wire logic [pazc_pkg::IndexWidth-1:0]         csr_index,
   input  wire logic [pazc_pkg::DataWidth-1:0]          csr_wdata,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_start_pressed,
   input  wire logic signed [pazc_pkg::SampleWidth-1:0] req_pressure,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_initialized,
   output logic                                         rsp_run_mode,
   output logic signed [pazc_pkg::SampleWidth-1:0]      rsp_zero_point,
   output logic                                         rsp_zero_written
);

   pazc_pkg::cfg_type cfg;
   pazc_pkg::res_type res;
   pazc_pkg::res_type rsp_data;
   logic              room;
   logic              take;

   assign req_stall = !room;
   assign take      = req_valid && room;

   pazc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pazc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .take          (take),
      .start_pressed (req_start_pressed),
      .pressure      (req_pressure),
      .res           (res)
   );

   pazc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .room      (room)
   );

   assign rsp_initialized  = rsp_data.initialized;
   assign rsp_run_mode     = rsp_data.run_mode;
   assign rsp_zero_point   = rsp_data.zero_point;
   assign rsp_zero_written = rsp_data.zero_written;

endmodule

`default_nettype wire

### rtl/pazc_checker.sv
`default_nettype none

module pazc_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    req_valid,
   input wire logic                                    req_stall,
   input wire logic                                    rsp_valid,
   input wire logic                                    rsp_stall,
   input wire logic                                    rsp_initialized,
   input wire logic                                    rsp_run_mode,
   input wire logic signed [pazc_pkg::SampleWidth-1:0] rsp_zero_point,
   input wire logic                                    rsp_zero_written
);

   // A stalled item stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   // A stalled item keeps its zero point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_zero_point))
      else $error("rsp_zero_point changed under stall");

   // Every accepted tick shows a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

   // Run mode and captures only after startup
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_run_mode || rsp_zero_written) |-> rsp_initialized)
      else $error("run or capture before initialization");

endmodule

bind pressure_auto_zero_controller pazc_checker u_pazc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_initialized  (rsp_initialized),
   .rsp_run_mode     (rsp_run_mode),
   .rsp_zero_point   (rsp_zero_point),
   .rsp_zero_written (rsp_zero_written)
);

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;

   // Register indexes past the end of the map, written to check they are ignored
   localparam logic [pazc_pkg::IndexWidth-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [pazc_pkg::IndexWidth-1:0] REG_SPARE_HI = 3'd7;

   localparam int MaxPrintedMismatches = 40;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    csr_we = 1'b0;
   logic [pazc_pkg::IndexWidth-1:0]         csr_index = '0;
   logic [pazc_pkg::DataWidth-1:0]          csr_wdata = '0;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic                                    req_start_pressed = 1'b0;
   logic signed [pazc_pkg::SampleWidth-1:0] req_pressure = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic                                    rsp_initialized;
   logic                                    rsp_run_mode;
   logic signed [pazc_pkg::SampleWidth-1:0] rsp_zero_point;
   logic                                    rsp_zero_written;

   // Predicted controller state and its register copies
   logic [pazc_pkg::TickWidth-1:0]   c_init_ticks;
   logic [pazc_pkg::TickWidth-1:0]   c_ticks_per_second;
   logic [pazc_pkg::DelayWidth-1:0]  c_delay_seconds;
   logic [pazc_pkg::TickWidth-1:0]   c_interval_seconds;
   logic [pazc_pkg::WindowWidth-1:0] c_zero_window;
   logic                             m_init_done;
   logic [pazc_pkg::TickWidth-1:0]   m_init_count;
   pazc_pkg::dly_phase_type          m_lockout_phase;
   logic [pazc_pkg::TickWidth-1:0]   m_lockout_ticks;
   logic [pazc_pkg::DelayWidth-1:0]  m_lockout_seconds;
   logic                             m_interval_running;
   logic [pazc_pkg::TickWidth-1:0]   m_interval_ticks;
   logic [pazc_pkg::TickWidth-1:0]   m_interval_seconds;
   logic                             m_interval_due;
   logic                             m_capture_locked;
   logic [pazc_pkg::SampleWidth-1:0] m_zero_value;
   logic                             m_run;

   pazc_pkg::res_type expected_status[$];
   int                mismatch_count = 0;
   int                tx_gap_pct = 8;
   int                rx_stall_pct = 62;
   int                rx_hold_len = 0;

   pressure_auto_zero_controller dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_pressed (req_start_pressed),
      .req_pressure      (req_pressure),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_initialized   (rsp_initialized),
      .rsp_run_mode      (rsp_run_mode),
      .rsp_zero_point    (rsp_zero_point),
      .rsp_zero_written  (rsp_zero_written)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count a mismatch and print it while fewer than MaxPrintedMismatches were seen
   task automatic flag_mismatch(input string msg);
      if (mismatch_count < MaxPrintedMismatches)
         $display("%0t: status mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Return the controller model to its power-on state
   task automatic reset_controller_model();
      c_init_ticks       = pazc_pkg::INIT_TICKS_RST;
      c_ticks_per_second = pazc_pkg::TICKS_PER_SECOND_RST;
      c_delay_seconds    = pazc_pkg::DELAY_SECONDS_RST;
      c_interval_seconds = pazc_pkg::INTERVAL_SECONDS_RST;
      c_zero_window      = pazc_pkg::ZERO_WINDOW_RST;
      m_init_done        = 1'b0;
      m_init_count       = '0;
      m_lockout_phase    = pazc_pkg::DLY_IDLE;
      m_lockout_ticks    = '0;
      m_lockout_seconds  = '0;
      m_interval_running = 1'b0;
      m_interval_ticks   = '0;
      m_interval_seconds = '0;
      m_interval_due     = 1'b0;
      m_capture_locked   = 1'b0;
      m_zero_value       = pazc_pkg::STORED_ZERO_RST;
      m_run              = 1'b0;
   endtask

   // Advance the controller model by one tick and queue the status it reports
   task automatic advance_controller(input logic start,
                                     input logic [pazc_pkg::SampleWidth-1:0] pbits);
      pazc_pkg::res_type                       status;
      logic                                    written;
      logic signed [pazc_pkg::SampleWidth-1:0] sample;
      int                                      magnitude;
      written = 1'b0;
      sample  = pbits;

      // startup timer
      if (!m_init_done) begin
         m_init_count = m_init_count + 16'd1;
         if (m_init_count > c_init_ticks) begin
            m_init_count = '0;
            m_init_done  = 1'b1;
         end
      end

      // lockout timer
      if (m_lockout_phase == pazc_pkg::DLY_RUN) begin
         m_lockout_ticks = m_lockout_ticks + 16'd1;
         if (m_lockout_ticks > c_ticks_per_second) begin
            m_lockout_ticks   = '0;
            m_lockout_seconds = m_lockout_seconds + 8'd1;
         end
         if (m_lockout_seconds > c_delay_seconds) begin
            m_lockout_seconds = '0;
            m_lockout_phase   = pazc_pkg::DLY_DONE;
         end
      end

      // interval timer
      if (m_interval_running) begin
         m_interval_ticks = m_interval_ticks + 16'd1;
         if (m_interval_ticks > c_ticks_per_second) begin
            m_interval_ticks   = '0;
            m_interval_seconds = m_interval_seconds + 16'd1;
         end
         if (m_interval_seconds > c_interval_seconds) begin
            m_interval_due     = 1'b1;
            m_interval_seconds = '0;
            m_interval_ticks   = '0;
         end
      end

      // switch handling once started up
      if (m_init_done) begin
         if (start) begin
            if (!m_capture_locked) begin
               m_zero_value      = pbits;
               written           = 1'b1;
               m_capture_locked  = 1'b1;
               m_lockout_ticks   = '0;
               m_lockout_seconds = '0;
               m_lockout_phase   = pazc_pkg::DLY_RUN;
            end
            m_interval_running = 1'b1;
            if (m_interval_due) begin
               magnitude      = (sample < 0) ? -int'(sample) : int'(sample);
               m_interval_due = 1'b0;
               if (magnitude < int'(c_zero_window)) begin
                  m_zero_value = pbits;
                  written      = 1'b1;
               end
            end
            m_run = 1'b1;
         end else begin
            if (m_lockout_phase == pazc_pkg::DLY_DONE)
               m_capture_locked = 1'b0;
            m_interval_ticks   = '0;
            m_interval_seconds = '0;
            m_interval_running = 1'b0;
            m_run              = 1'b0;
         end
      end

      status.initialized  = m_init_done;
      status.run_mode     = m_run;
      status.zero_point   = m_zero_value;
      status.zero_written = written;
      expected_status.push_back(status);
   endtask

   // Offer one tick, hold it until taken, then predict its status
   task automatic send_tick(input logic start,
                            input logic [pazc_pkg::SampleWidth-1:0] pbits);
      if ($urandom_range(99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_start_pressed <= start;
      req_pressure      <= pbits;
      @(negedge clock);
      while (req_stall !== 1'b0) @(negedge clock);
      @(posedge clock);
      advance_controller(start, pbits);
   endtask

   // Stop offering and wait until every predicted status has been seen
   task automatic wait_results_settled();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_reg(input logic [pazc_pkg::IndexWidth-1:0] idx,
                            input logic [pazc_pkg::DataWidth-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         pazc_pkg::REG_INIT_TICKS:       c_init_ticks = data;
         pazc_pkg::REG_TICKS_PER_SECOND: c_ticks_per_second = data;
         pazc_pkg::REG_DELAY_SECONDS:
            c_delay_seconds = data[pazc_pkg::DelayWidth-1:0];
         pazc_pkg::REG_INTERVAL_SECONDS: c_interval_seconds = data;
         pazc_pkg::REG_ZERO_WINDOW:
            c_zero_window = data[pazc_pkg::WindowWidth-1:0];
         pazc_pkg::REG_STORED_ZERO:      m_zero_value = data;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Pick a pressure: 40% in and just around the window, 10% extremes and window edges, the rest anywhere
   function automatic logic [pazc_pkg::SampleWidth-1:0] pick_pressure();
      int w;
      int sel;
      int v;
      w   = int'(c_zero_window);
      sel = $urandom_range(99);
      if (sel < 40) begin
         v = int'($urandom_range(0, 2 * w + 4)) - (w + 2);
         return 16'(v);
      end
      if (sel < 50) begin
         case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(w);
            4: return 16'(-w);
            default: return 16'(w - 1);
         endcase
      end
      return 16'($urandom);
   endfunction

   // Run switch sessions: held stretches and releases, with some random chatter
   task automatic run_operation(input int n_items);
      int left;
      int len;
      left = n_items;
      while (left > 0) begin
         if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, 6);
            repeat (len) send_tick(1'($urandom_range(1)), pick_pressure());
            left -= len;
         end else begin
            len = $urandom_range(1, 24);
            repeat (len) send_tick(1'b1, pick_pressure());
            left -= len;
            len = $urandom_range(1, 8);
            repeat (len) send_tick(1'b0, pick_pressure());
            left -= len;
         end
      end
   endtask

   // Program a random setting, short timers mostly, limits now and then
   task automatic pick_settings(input logic reload_zero);
      logic [pazc_pkg::DataWidth-1:0] tps;
      logic [pazc_pkg::DataWidth-1:0] ivl;
      logic [7:0]                     dly;
      logic [14:0]                    win;
      tps = ($urandom_range(9) == 0) ? 16'hFFFF - 16'($urandom_range(1))
                                     : 16'($urandom_range(0, 3));
      ivl = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
      dly = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(0, 4));
      case ($urandom_range(5))
         0: win = '0;
         1: win = 15'h7FFF;
         default: win = 15'($urandom_range(1, 40));
      endcase
      write_reg(pazc_pkg::REG_INIT_TICKS, 16'($urandom));
      write_reg(pazc_pkg::REG_TICKS_PER_SECOND, tps);
      write_reg(pazc_pkg::REG_DELAY_SECONDS, {8'($urandom), dly});
      write_reg(pazc_pkg::REG_INTERVAL_SECONDS, ivl);
      write_reg(pazc_pkg::REG_ZERO_WINDOW, {1'($urandom), win});
      if (reload_zero)
         write_reg(pazc_pkg::REG_STORED_ZERO, 16'($urandom));
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
   endtask

   // Nothing happens until startup completes; boot value shows as the zero point
   task automatic test_startup_gate();
      write_reg(pazc_pkg::REG_STORED_ZERO, 16'h8000);
      send_tick(1'b1, 16'h7FFF);
      send_tick(1'b1, 16'h8000);
      send_tick(1'b0, 16'h0000);
      wait_results_settled();
      write_reg(pazc_pkg::REG_INIT_TICKS, 16'hFFFF);
      send_tick(1'b1, 16'h0001);
      send_tick(1'b1, 16'hFFFF);
      wait_results_settled();
      write_reg(pazc_pkg::REG_INIT_TICKS, 16'h0000);
      send_tick(1'b0, 16'h0000);
      wait_results_settled();
   endtask

   // First press captures; re-arm only after a release once lockout is over
   task automatic test_first_capture_lockout();
      write_reg(pazc_pkg::REG_TICKS_PER_SECOND, 16'd0);
      write_reg(pazc_pkg::REG_DELAY_SECONDS, 16'd2);
      write_reg(pazc_pkg::REG_INTERVAL_SECONDS, 16'hFFFF);
      write_reg(pazc_pkg::REG_ZERO_WINDOW, 16'd15);
      send_tick(1'b1, 16'h7FFF);
      send_tick(1'b1, 16'd100);
      send_tick(1'b0, 16'd5);
      send_tick(1'b1, 16'd7);
      send_tick(1'b0, 16'd9);
      send_tick(1'b1, 16'h8000);
      wait_results_settled();
   endtask

   // Periodic re-zero inside the window only, and a due flag kept over a release
   task automatic test_periodic_rezero();
      logic [pazc_pkg::SampleWidth-1:0] samples[8];
      samples = '{16'd14, 16'd14, 16'd15, 16'd15, -16'sd14, -16'sd14, 16'h8000, 16'h8000};
      write_reg(pazc_pkg::REG_INTERVAL_SECONDS, 16'd1);
      foreach (samples[i]) send_tick(1'b1, samples[i]);
      send_tick(1'b0, 16'd0);
      send_tick(1'b1, 16'd20);
      send_tick(1'b1, 16'd21);
      send_tick(1'b0, 16'd22);
      send_tick(1'b0, 16'd23);
      send_tick(1'b1, -16'sd3);
      wait_results_settled();
   endtask

   // Tick, lockout, interval and window registers at their lowest with a zero stored zero, then all at their highest
   task automatic test_register_extremes();
      write_reg(pazc_pkg::REG_TICKS_PER_SECOND, 16'h0000);
      write_reg(pazc_pkg::REG_DELAY_SECONDS, 16'h0000);
      write_reg(pazc_pkg::REG_INTERVAL_SECONDS, 16'h0000);
      write_reg(pazc_pkg::REG_ZERO_WINDOW, 16'h0000);
      write_reg(pazc_pkg::REG_STORED_ZERO, 16'h0000);
      write_reg(REG_SPARE_LO, 16'hFFFF);
      run_operation(60);
      wait_results_settled();
      write_reg(pazc_pkg::REG_INIT_TICKS, 16'hFFFF);
      write_reg(pazc_pkg::REG_TICKS_PER_SECOND, 16'hFFFF);
      write_reg(pazc_pkg::REG_DELAY_SECONDS, 16'hFFFF);
      write_reg(pazc_pkg::REG_INTERVAL_SECONDS, 16'hFFFF);
      write_reg(pazc_pkg::REG_ZERO_WINDOW, 16'hFFFF);
      write_reg(pazc_pkg::REG_STORED_ZERO, 16'h7FFF);
      write_reg(REG_SPARE_HI, 16'hFFFF);
      run_operation(60);
      wait_results_settled();
   endtask

   // Long receiver hold while ticks keep coming, then a full drain before more
   task automatic test_backpressure();
      write_reg(pazc_pkg::REG_TICKS_PER_SECOND, 16'd1);
      write_reg(pazc_pkg::REG_DELAY_SECONDS, 16'd1);
      write_reg(pazc_pkg::REG_INTERVAL_SECONDS, 16'd2);
      write_reg(pazc_pkg::REG_ZERO_WINDOW, 16'd30);
      tx_gap_pct  = 0;
      rx_hold_len = 60;
      repeat (20) send_tick(1'b1, pick_pressure());
      wait_results_settled();
      repeat (10) send_tick(1'($urandom_range(1)), pick_pressure());
      wait_results_settled();
   endtask

   // Random sessions under each idling mix
   task automatic test_random_operation();
      for (int phase = 0; phase < 12; phase++) begin
         case (phase / 4)
            0: begin
               tx_gap_pct   = 8;
               rx_stall_pct = 62;
            end
            1: begin
               tx_gap_pct   = 62;
               rx_stall_pct = 8;
            end
            default: begin
               tx_gap_pct   = 0;
               rx_stall_pct = 0;
            end
         endcase
         wait_results_settled();
         pick_settings(phase % 3 == 0);
         run_operation(70);
      end
      wait_results_settled();
   endtask

   // Drive receiver stall: hold-off stretch first, random stalls otherwise
   always @(posedge clock) begin
      if (rx_hold_len > 0) begin
         rsp_stall <= 1'b1;
         rx_hold_len = rx_hold_len - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   // Compare each taken status item with the oldest prediction
   always @(negedge clock) begin
      pazc_pkg::res_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_status.size() == 0) begin
            flag_mismatch("status item with nothing expected");
         end else begin
            want = expected_status.pop_front();
            if (rsp_initialized !== want.initialized)
               flag_mismatch($sformatf("initialized got %b want %b",
                                       rsp_initialized, want.initialized));
            if (rsp_run_mode !== want.run_mode)
               flag_mismatch($sformatf("run_mode got %b want %b",
                                       rsp_run_mode, want.run_mode));
            if (rsp_zero_point !== want.zero_point)
               flag_mismatch($sformatf("zero_point got %0d want %0d",
                                       rsp_zero_point, want.zero_point));
            if (rsp_zero_written !== want.zero_written)
               flag_mismatch($sformatf("zero_written got %b want %b",
                                       rsp_zero_written, want.zero_written));
         end
      end
   end

   initial begin
      reset_controller_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_startup_gate();
      test_first_capture_lockout();
      test_periodic_rezero();
      test_register_extremes();
      test_backpressure();
      test_random_operation();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("pressure_auto_zero_controller regression: pass");
      else
         $display("pressure_auto_zero_controller regression: fail");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("pressure_auto_zero_controller regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/pazc_pkg.sv
rtl/pazc_csr.sv
rtl/pazc_core.sv
rtl/pazc_out.sv
rtl/pressure_auto_zero_controller.sv
rtl/pazc_checker.sv
tb/tb_top.sv
